// ----- hw/rtl/srecord_s2_encoder_top_macros.svh -----
// ---------------------------------------------------------------------------
// S2 record encoder assertion macros
// Shared property forms for the concurrent checks of the encoder.
// ---------------------------------------------------------------------------
`ifndef SRECORD_S2_ENCODER_TOP_MACROS_SVH
`define SRECORD_S2_ENCODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SREC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must never be true.
`define SREC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ----- hw/rtl/srec_s2_pkg.sv -----
// ---------------------------------------------------------------------------
// S2 record encoder package
// Widths, register indexes, character positions and the queue entry type.
// ---------------------------------------------------------------------------
package srec_s2_pkg;

	// Field and state widths.
	localparam int ADDR_W      = 24;
	localparam int TOTAL_W     = 16;
	localparam int LEN_W       = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int POS_W       = 4;

	// Record shape: at most this many data bytes per record.
	localparam int RECORD_DATA_MAX = 12;
	localparam logic [LEN_W-1:0]   RECORD_LEN_MAX      = LEN_W'(RECORD_DATA_MAX);
	localparam logic [TOTAL_W-1:0] RECORD_LEN_MAX_WIDE = TOTAL_W'(RECORD_DATA_MAX);

	// The count field covers the data plus three address bytes and the checksum.
	localparam logic [7:0] COUNT_OVERHEAD = 8'd4;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_START_ADDRESS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_LENGTH  = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [ADDR_W-1:0]  START_ADDRESS_RESET = '0;
	localparam logic [TOTAL_W-1:0] TOTAL_LENGTH_RESET  = 16'd1;

	// Character positions within one record word sequence.
	localparam logic [POS_W-1:0] POS_S        = 4'd0;
	localparam logic [POS_W-1:0] POS_TWO      = 4'd1;
	localparam logic [POS_W-1:0] POS_CNT_HI   = 4'd2;
	localparam logic [POS_W-1:0] POS_CNT_LO   = 4'd3;
	localparam logic [POS_W-1:0] POS_A5       = 4'd4;
	localparam logic [POS_W-1:0] POS_A4       = 4'd5;
	localparam logic [POS_W-1:0] POS_A3       = 4'd6;
	localparam logic [POS_W-1:0] POS_A2       = 4'd7;
	localparam logic [POS_W-1:0] POS_A1       = 4'd8;
	localparam logic [POS_W-1:0] POS_A0       = 4'd9;
	localparam logic [POS_W-1:0] POS_DATA_HI  = 4'd10;
	localparam logic [POS_W-1:0] POS_DATA_LO  = 4'd11;
	localparam logic [POS_W-1:0] POS_SUM_HI   = 4'd12;
	localparam logic [POS_W-1:0] POS_SUM_LO   = 4'd13;
	localparam logic [POS_W-1:0] POS_NEWLINE  = 4'd14;

	// Fixed characters.
	localparam logic [7:0] CHAR_S       = 8'h53;
	localparam logic [7:0] CHAR_TWO     = 8'h32;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	// Queue between the front and the back; depth is a power of two.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QUEUE_CW-1:0] QUEUE_FULL_COUNT = QUEUE_CW'(QUEUE_DEPTH);

	// One classified data byte: what the back must print for it.
	typedef struct packed {
		logic              hdr;
		logic [7:0]        count;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
		logic              trl;
		logic [7:0]        csum;
		logic              done;
	} rec_entry_t;

	// Upper-case ASCII hex digit of a nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] wide;
		wide = {4'h0, nib};
		if (nib < 4'd10) begin
			return 8'h30 + wide;
		end
		return 8'h37 + wide;
	endfunction

endpackage

// ----- hw/rtl/srec_s2_if.sv -----
// ---------------------------------------------------------------------------
// S2 record encoder channel interfaces
// Valid/ready channels for data bytes, text characters and register writes.
// ---------------------------------------------------------------------------

// Input channel: one data byte per word.
interface srec_s2_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// Output channel: one text character per word.
interface srec_s2_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       last_of_run;
	logic       image_done;

	modport source (output valid, output text_char, output last_of_run,
		output image_done, input ready);
	modport sink (input valid, input text_char, input last_of_run,
		input image_done, output ready);
endinterface

// Configuration write channel: register index and write data.
interface srec_s2_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [srec_s2_pkg::CFG_INDEX_W-1:0]   index;
	logic [srec_s2_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/srec_s2_front.sv -----
// ---------------------------------------------------------------------------
// S2 record encoder front end
// Holds the configuration and image state, and classifies each data byte
// into a queue entry: header or not, trailer or not, and the checksum.
// ---------------------------------------------------------------------------
module srec_s2_front (
	input  logic                    clk,
	input  logic                    arst_n,
	srec_s2_byte_if.sink            byte_in,
	srec_s2_cfg_if.sink             cfg,
	input  logic                    q_full,
	output logic                    q_push,
	output srec_s2_pkg::rec_entry_t q_entry
);

	logic [srec_s2_pkg::ADDR_W-1:0]  start_q;
	logic [srec_s2_pkg::TOTAL_W-1:0] total_q;
	logic [srec_s2_pkg::TOTAL_W-1:0] rem_q;
	logic [srec_s2_pkg::LEN_W-1:0]   rec_left_q;
	logic [srec_s2_pkg::ADDR_W-1:0]  addr_q;
	logic [7:0]                      csum_q;

	logic                            accept;
	logic                            new_rec;
	logic [srec_s2_pkg::LEN_W-1:0]   len;
	logic [7:0]                      count;
	logic [7:0]                      hdr_sum;
	logic [7:0]                      sum;
	logic [srec_s2_pkg::LEN_W-1:0]   left_next;
	logic [srec_s2_pkg::TOTAL_W-1:0] rem_next;
	logic                            trl;
	logic                            cfg_wr;

	// Bytes are taken whenever the queue has room; a byte after the image ends is dropped.
	assign byte_in.ready = !q_full;
	assign accept        = byte_in.valid && byte_in.ready;
	assign q_push        = accept && (rem_q != '0);
	assign cfg.ready     = 1'b1;
	assign cfg_wr        = cfg.valid && cfg.ready;

	// Classify the byte against the record state.
	always_comb begin
		new_rec = (rec_left_q == '0);
		if (rem_q < srec_s2_pkg::RECORD_LEN_MAX_WIDE) begin
			len = rem_q[srec_s2_pkg::LEN_W-1:0];
		end else begin
			len = srec_s2_pkg::RECORD_LEN_MAX;
		end
		count   = 8'(len) + srec_s2_pkg::COUNT_OVERHEAD;
		hdr_sum = count + addr_q[23:16] + addr_q[15:8] + addr_q[7:0];
		sum     = (new_rec ? hdr_sum : csum_q) + byte_in.data_byte;
		left_next = (new_rec ? len : rec_left_q) - 1'b1;
		rem_next  = rem_q - 1'b1;
		trl       = (left_next == '0) || (rem_next == '0);

		q_entry.hdr   = new_rec;
		q_entry.count = count;
		q_entry.addr  = addr_q;
		q_entry.data  = byte_in.data_byte;
		q_entry.trl   = trl;
		q_entry.csum  = ~sum;
		q_entry.done  = (rem_next == '0);
	end

	// Configuration registers and image state; a write to a decoded register restarts the image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= srec_s2_pkg::START_ADDRESS_RESET;
			total_q    <= srec_s2_pkg::TOTAL_LENGTH_RESET;
			rem_q      <= srec_s2_pkg::TOTAL_LENGTH_RESET;
			rec_left_q <= '0;
			addr_q     <= srec_s2_pkg::START_ADDRESS_RESET;
			csum_q     <= '0;
		end else if (cfg_wr) begin
			if (cfg.index == srec_s2_pkg::REG_START_ADDRESS) begin
				start_q    <= cfg.data;
				rem_q      <= total_q;
				rec_left_q <= '0;
				addr_q     <= cfg.data;
				csum_q     <= '0;
			end else if (cfg.index == srec_s2_pkg::REG_TOTAL_LENGTH) begin
				total_q    <= cfg.data[srec_s2_pkg::TOTAL_W-1:0];
				rem_q      <= cfg.data[srec_s2_pkg::TOTAL_W-1:0];
				rec_left_q <= '0;
				addr_q     <= start_q;
				csum_q     <= '0;
			end
		end else if (q_push) begin
			rem_q      <= rem_next;
			addr_q     <= addr_q + 1'b1;
			rec_left_q <= trl ? '0 : left_next;
			csum_q     <= trl ? 8'h00 : sum;
		end
	end

endmodule

// ----- hw/rtl/srec_s2_queue.sv -----
// ---------------------------------------------------------------------------
// S2 record encoder entry queue
// Small first-in first-out buffer of classified bytes between front and back.
// ---------------------------------------------------------------------------
module srec_s2_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  srec_s2_pkg::rec_entry_t push_entry,
	input  logic                    pop,
	output logic                    full,
	output logic                    head_valid,
	output srec_s2_pkg::rec_entry_t head_entry
);

	srec_s2_pkg::rec_entry_t               slots_q [srec_s2_pkg::QUEUE_DEPTH];
	logic [srec_s2_pkg::QUEUE_AW-1:0]      wr_ptr_q;
	logic [srec_s2_pkg::QUEUE_AW-1:0]      rd_ptr_q;
	logic [srec_s2_pkg::QUEUE_CW-1:0]      count_q;
	logic                                  do_pop;

	assign full       = (count_q == srec_s2_pkg::QUEUE_FULL_COUNT);
	assign head_valid = (count_q != '0);
	assign head_entry = slots_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push && !full) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers wrap naturally since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if ((push && !full) && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !(push && !full)) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/srec_s2_back.sv -----
// ---------------------------------------------------------------------------
// S2 record encoder back end
// Walks the characters of the queue head entry into the output register,
// one per cycle while the receiver does not stall the output word.
// ---------------------------------------------------------------------------
module srec_s2_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  srec_s2_pkg::rec_entry_t head_entry,
	output logic                    pop,
	srec_s2_text_if.source          text_out
);

	logic [srec_s2_pkg::POS_W-1:0] pos_q;
	logic [srec_s2_pkg::POS_W-1:0] eff_pos;
	logic                          advance;
	logic                          is_last;
	logic [7:0]                    chr;
	logic                          out_valid_q;
	logic [7:0]                    out_char_q;
	logic                          out_last_q;
	logic                          out_done_q;

	// An entry without a header starts at its first data digit.
	assign eff_pos = head_entry.hdr ? pos_q : (pos_q + srec_s2_pkg::POS_DATA_HI);
	assign advance = head_valid && (!out_valid_q || text_out.ready);
	assign is_last = ((eff_pos == srec_s2_pkg::POS_DATA_LO) && !head_entry.trl)
		|| (eff_pos == srec_s2_pkg::POS_NEWLINE);
	assign pop     = advance && is_last;

	// Character select by position.
	always_comb begin
		unique case (eff_pos)
			srec_s2_pkg::POS_S:       chr = srec_s2_pkg::CHAR_S;
			srec_s2_pkg::POS_TWO:     chr = srec_s2_pkg::CHAR_TWO;
			srec_s2_pkg::POS_CNT_HI:  chr = srec_s2_pkg::hex_char(head_entry.count[7:4]);
			srec_s2_pkg::POS_CNT_LO:  chr = srec_s2_pkg::hex_char(head_entry.count[3:0]);
			srec_s2_pkg::POS_A5:      chr = srec_s2_pkg::hex_char(head_entry.addr[23:20]);
			srec_s2_pkg::POS_A4:      chr = srec_s2_pkg::hex_char(head_entry.addr[19:16]);
			srec_s2_pkg::POS_A3:      chr = srec_s2_pkg::hex_char(head_entry.addr[15:12]);
			srec_s2_pkg::POS_A2:      chr = srec_s2_pkg::hex_char(head_entry.addr[11:8]);
			srec_s2_pkg::POS_A1:      chr = srec_s2_pkg::hex_char(head_entry.addr[7:4]);
			srec_s2_pkg::POS_A0:      chr = srec_s2_pkg::hex_char(head_entry.addr[3:0]);
			srec_s2_pkg::POS_DATA_HI: chr = srec_s2_pkg::hex_char(head_entry.data[7:4]);
			srec_s2_pkg::POS_DATA_LO: chr = srec_s2_pkg::hex_char(head_entry.data[3:0]);
			srec_s2_pkg::POS_SUM_HI:  chr = srec_s2_pkg::hex_char(head_entry.csum[7:4]);
			srec_s2_pkg::POS_SUM_LO:  chr = srec_s2_pkg::hex_char(head_entry.csum[3:0]);
			srec_s2_pkg::POS_NEWLINE: chr = srec_s2_pkg::CHAR_NEWLINE;
			default:                  chr = 8'h00;
		endcase
	end

	// Position counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pos_q       <= is_last ? '0 : (pos_q + 1'b1);
				out_valid_q <= 1'b1;
			end else if (text_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output word payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_char_q <= chr;
			out_last_q <= is_last;
			out_done_q <= head_entry.done && (eff_pos == srec_s2_pkg::POS_NEWLINE);
		end
	end

	assign text_out.valid       = out_valid_q;
	assign text_out.text_char   = out_char_q;
	assign text_out.last_of_run = out_last_q;
	assign text_out.image_done  = out_done_q;

endmodule

// ----- hw/rtl/srecord_s2_encoder_top.sv -----
// ---------------------------------------------------------------------------
// Motorola S2 record encoder
// Turns a stream of image bytes into S2 record text, one character a word.
// ---------------------------------------------------------------------------
// Usage:
// The byte_in channel takes one data byte per word, in address order.
// The text_out channel gives one ASCII character per word; last_of_run marks
// the last character caused by a byte and image_done the final newline.
// The cfg channel writes start_address (index 0) and total_length (index 1);
// each write restarts the image from the held values. Write only when idle.
// A byte gives 2 characters, 12 with a record header, 5 with a checksum and
// newline, or 15 with both; the output register moves one character per cycle
// while not stalled, so a full record of 12 bytes is 37 characters of text.
// With nothing ahead of it in the queue, an accepted byte is written into the
// queue and its first character then goes straight to the output register.
// The front takes a byte every cycle while the four-entry queue has room;
// when the receiver stalls, the output word holds and the queue fills, then
// byte_in.ready drops. Bytes past the end of the image are taken and dropped.
// After reset start_address is 0 and total_length is 1; the queue is empty.
// ---------------------------------------------------------------------------
`include "srecord_s2_encoder_top_macros.svh"

module srecord_s2_encoder_top (
	input  logic           clk,
	input  logic           arst_n,
	srec_s2_byte_if.sink   byte_in,
	srec_s2_text_if.source text_out,
	srec_s2_cfg_if.sink    cfg
);

	logic                    q_push;
	logic                    q_full;
	logic                    q_pop;
	logic                    q_head_valid;
	srec_s2_pkg::rec_entry_t q_push_entry;
	srec_s2_pkg::rec_entry_t q_head_entry;

	// Front end: state and classification.
	srec_s2_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.cfg     (cfg),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_push_entry)
	);

	// Queue of classified bytes.
	srec_s2_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head_entry (q_head_entry)
	);

	// Back end: character sequencing.
	srec_s2_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_entry (q_head_entry),
		.pop        (q_pop),
		.text_out   (text_out)
	);

	// The final newline always closes a run of characters.
	`SREC_ASSERT_IMPLY(a_done_is_last, clk, arst_n,
		text_out.valid && text_out.image_done, text_out.last_of_run,
		"image_done without last_of_run")
	// The final word of the image is a newline.
	`SREC_ASSERT_IMPLY(a_done_newline, clk, arst_n,
		text_out.valid && text_out.image_done,
		text_out.text_char == srec_s2_pkg::CHAR_NEWLINE,
		"image_done on a character other than newline")
	// The back end only retires an entry that is present.
	`SREC_ASSERT_NEVER(a_pop_empty, clk, arst_n, q_pop && !q_head_valid, "queue popped while empty")

endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// S2 record encoder testbench
// Drives data bytes and register writes into the encoder and checks every
// text word against typed text or an S2 record format predictor. A directed
// table comes first, then random images under three flow-control phases.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Register indexes that the encoder does not decode.
	localparam logic [srec_s2_pkg::CFG_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [srec_s2_pkg::CFG_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;

	// Quiet cycles before a register write and at the end of the run.
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASE_BYTES   = 135;
	localparam int REPORT_MAX    = 10;

	typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

	// One row of the directed stimulus table.
	typedef struct {
		row_kind_t                             kind;
		logic [srec_s2_pkg::CFG_INDEX_W-1:0]   index;
		logic [srec_s2_pkg::CFG_DATA_W-1:0]    data;
		logic [7:0]                            data_byte;
		bit                                    known;
		string                                 text;
		bit                                    done;
	} stim_row_t;

	// One expected text word.
	typedef struct {
		logic [7:0] text_char;
		logic       last_of_run;
		logic       image_done;
	} text_word_t;

	logic clk;
	logic arst_n;

	srec_s2_byte_if byte_if();
	srec_s2_text_if text_if();
	srec_s2_cfg_if  cfg_if();

	srecord_s2_encoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_if),
		.text_out (text_if),
		.cfg      (cfg_if)
	);

	// Predictor copy of the registers and the encoder state.
	logic [srec_s2_pkg::ADDR_W-1:0]  cfg_start;
	logic [srec_s2_pkg::TOTAL_W-1:0] cfg_total;
	logic [srec_s2_pkg::TOTAL_W-1:0] img_remaining;
	logic [srec_s2_pkg::LEN_W-1:0]   rec_left;
	logic [srec_s2_pkg::ADDR_W-1:0]  rec_addr;
	logic [7:0]                      rec_sum;

	text_word_t text_expected[$];
	stim_row_t  stim_rows[$];

	int sender_idle_pct;
	int receiver_stall_pct;
	int mismatch_count;
	int bytes_sent;
	int bytes_encoded;
	int phase_bytes;
	int words_seen;
	int writes_done;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Upper-case ASCII digit for one nibble.
	function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return 8'h30 + {4'h0, nib};
		end
		return 8'h41 + {4'h0, nib} - 8'd10;
	endfunction

	// Reload the encoder state from the held register values.
	function automatic void restart_image();
		img_remaining = cfg_total;
		rec_left      = '0;
		rec_addr      = cfg_start;
		rec_sum       = '0;
	endfunction

	// Register write as the encoder applies it; unknown indexes change nothing.
	function automatic void apply_write(input logic [srec_s2_pkg::CFG_INDEX_W-1:0] index,
		input logic [srec_s2_pkg::CFG_DATA_W-1:0] data);
		case (index)
			srec_s2_pkg::REG_START_ADDRESS: begin
				cfg_start = data[srec_s2_pkg::ADDR_W-1:0];
				restart_image();
			end
			srec_s2_pkg::REG_TOTAL_LENGTH: begin
				cfg_total = data[srec_s2_pkg::TOTAL_W-1:0];
				restart_image();
			end
			default: begin
			end
		endcase
	endfunction

	// Encode one data byte into record text. Returns the number of characters;
	// they are queued as expected words only when queue_it is set.
	function automatic int encode_byte(input logic [7:0] b, input bit queue_it);
		logic [7:0] chars[$];
		logic [3:0] len;
		logic [7:0] count;
		logic       done;
		text_word_t w;
		if (img_remaining == '0) begin
			return 0;
		end
		done = 1'b0;
		// A new record opens with its header.
		if (rec_left == '0) begin
			len = (img_remaining < srec_s2_pkg::TOTAL_W'(srec_s2_pkg::RECORD_DATA_MAX))
				? img_remaining[3:0]
				: srec_s2_pkg::LEN_W'(srec_s2_pkg::RECORD_DATA_MAX);
			count = {4'h0, len} + 8'd4;
			chars.push_back(srec_s2_pkg::CHAR_S);
			chars.push_back(srec_s2_pkg::CHAR_TWO);
			chars.push_back(ascii_hex(count[7:4]));
			chars.push_back(ascii_hex(count[3:0]));
			for (int k = 5; k >= 0; k--) begin
				chars.push_back(ascii_hex(rec_addr[k*4 +: 4]));
			end
			rec_sum = count + rec_addr[23:16] + rec_addr[15:8] + rec_addr[7:0];
			rec_left = len;
		end
		chars.push_back(ascii_hex(b[7:4]));
		chars.push_back(ascii_hex(b[3:0]));
		rec_sum       = rec_sum + b;
		rec_addr      = rec_addr + 1'b1;
		img_remaining = img_remaining - 1'b1;
		rec_left      = rec_left - 1'b1;
		// The record's last byte closes it with checksum and newline.
		if (rec_left == '0 || img_remaining == '0) begin
			chars.push_back(ascii_hex(~rec_sum[7:4]));
			chars.push_back(ascii_hex(~rec_sum[3:0]));
			chars.push_back(srec_s2_pkg::CHAR_NEWLINE);
			done     = (img_remaining == '0);
			rec_left = '0;
			rec_sum  = '0;
		end
		if (queue_it) begin
			foreach (chars[i]) begin
				w.text_char   = chars[i];
				w.last_of_run = (i == chars.size() - 1);
				w.image_done  = (i == chars.size() - 1) && done;
				text_expected.push_back(w);
			end
		end
		return chars.size();
	endfunction

	// Count a failure and describe the first few.
	function automatic void flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
	endfunction

	// Table builders for the directed part.
	function automatic void add_write(input logic [srec_s2_pkg::CFG_INDEX_W-1:0] index,
		input logic [srec_s2_pkg::CFG_DATA_W-1:0] data);
		stim_row_t r;
		r.kind  = ROW_WRITE;
		r.index = index;
		r.data  = data;
		r.known = 1'b0;
		stim_rows.push_back(r);
	endfunction

	function automatic void add_byte(input logic [7:0] b, input bit known,
		input string text, input bit done);
		stim_row_t r;
		r.kind      = ROW_BYTE;
		r.data_byte = b;
		r.known     = known;
		r.text      = text;
		r.done      = done;
		stim_rows.push_back(r);
	endfunction

	// Send one data word; called just after a rising edge. The valid stays
	// high after acceptance so back-to-back words need no extra assignment.
	task automatic send_byte(input logic [7:0] b, input bit known, input string text,
		input bit done);
		int n;
		text_word_t w;
		while ($urandom_range(99) < sender_idle_pct) begin
			byte_if.valid <= 1'b0;
			@(posedge clk);
		end
		byte_if.valid     <= 1'b1;
		byte_if.data_byte <= b;
		do @(posedge clk); while (!byte_if.ready);
		n = encode_byte(b, !known);
		// Rows with typed text take that text as the expectation.
		if (known) begin
			for (int i = 0; i < text.len(); i++) begin
				w.text_char   = text[i];
				w.last_of_run = (i == text.len() - 1);
				w.image_done  = (i == text.len() - 1) && done;
				text_expected.push_back(w);
			end
		end
		bytes_sent++;
		if (n > 0) begin
			bytes_encoded++;
			phase_bytes++;
		end
	endtask

	// Register write once the encoder has gone quiet.
	task automatic write_reg(input logic [srec_s2_pkg::CFG_INDEX_W-1:0] index,
		input logic [srec_s2_pkg::CFG_DATA_W-1:0] data);
		byte_if.valid <= 1'b0;
		do @(posedge clk); while (text_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= index;
		cfg_if.data  <= data;
		do @(posedge clk); while (!cfg_if.ready);
		apply_write(index, data);
		cfg_if.valid <= 1'b0;
		writes_done++;
	endtask

	// One random image: mostly complete, sometimes cut short or followed by
	// bytes past its end.
	task automatic random_image();
		logic [srec_s2_pkg::ADDR_W-1:0]     start;
		logic [srec_s2_pkg::TOTAL_W-1:0]    len;
		logic [srec_s2_pkg::CFG_DATA_W-1:0] len_data;
		int n_send;
		int extra;
		case ($urandom_range(9))
			0: start = '0;
			1: start = '1;
			2, 3: start = 24'hFFFFFF - srec_s2_pkg::ADDR_W'($urandom_range(30));
			default: start = srec_s2_pkg::ADDR_W'($urandom());
		endcase
		case ($urandom_range(19))
			0: len = '0;
			1: len = 16'd12;
			2: len = 16'd13;
			3: len = 16'd24;
			4: len = 16'd1;
			default: len = srec_s2_pkg::TOTAL_W'($urandom_range(2, 40));
		endcase
		// The upper data bits of a length write carry noise.
		len_data = {8'($urandom()), len};
		if ($urandom_range(7) == 0) begin
			write_reg($urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3,
				srec_s2_pkg::CFG_DATA_W'($urandom()));
		end
		case ($urandom_range(9))
			0: write_reg(srec_s2_pkg::REG_TOTAL_LENGTH, len_data);
			1: write_reg(srec_s2_pkg::REG_START_ADDRESS, start);
			2: begin
				write_reg(srec_s2_pkg::REG_TOTAL_LENGTH, len_data);
				write_reg(srec_s2_pkg::REG_START_ADDRESS, start);
			end
			default: begin
				write_reg(srec_s2_pkg::REG_START_ADDRESS, start);
				write_reg(srec_s2_pkg::REG_TOTAL_LENGTH, len_data);
			end
		endcase
		n_send = (cfg_total > 16'd48) ? 48 : int'(cfg_total);
		extra  = $urandom_range(2);
		if (n_send > 1 && $urandom_range(99) < 15) begin
			n_send = $urandom_range(1, n_send - 1);
			extra  = 0;
		end
		repeat (n_send + extra) send_byte(8'($urandom()), 1'b0, "", 1'b0);
	endtask

	// Text receiver: checks each accepted word, then picks the next ready.
	initial begin
		text_word_t want;
		text_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && text_if.valid && text_if.ready) begin
				words_seen++;
				if (text_expected.size() == 0) begin
					flag_error($sformatf("unexpected text word char %h last %b done %b",
						text_if.text_char, text_if.last_of_run, text_if.image_done));
				end else begin
					want = text_expected.pop_front();
					if (text_if.text_char !== want.text_char
						|| text_if.last_of_run !== want.last_of_run
						|| text_if.image_done !== want.image_done) begin
						flag_error($sformatf(
							"word %0d: expected char %h last %b done %b, got char %h last %b done %b",
							words_seen, want.text_char, want.last_of_run, want.image_done,
							text_if.text_char, text_if.last_of_run, text_if.image_done));
					end
				end
			end
			text_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Run limit.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped after %0d cycles with %0d text words still due.",
			cycles, text_expected.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Stimulus sequence.
	initial begin
		mismatch_count     = 0;
		bytes_sent         = 0;
		bytes_encoded      = 0;
		phase_bytes        = 0;
		words_seen         = 0;
		writes_done        = 0;
		sender_idle_pct    = 6;
		receiver_stall_pct = 73;
		cfg_start          = srec_s2_pkg::START_ADDRESS_RESET;
		cfg_total          = srec_s2_pkg::TOTAL_LENGTH_RESET;
		restart_image();
		arst_n            <= 1'b0;
		byte_if.valid     <= 1'b0;
		byte_if.data_byte <= '0;
		cfg_if.valid      <= 1'b0;
		cfg_if.index      <= '0;
		cfg_if.data       <= '0;

		// Directed table. After reset the image is one byte at address zero.
		add_byte(8'hAB, 1'b1, "S205000000AB4F\n", 1'b1);
		add_byte(8'h12, 1'b1, "", 1'b0);
		// Top address with a one-byte image.
		add_write(srec_s2_pkg::REG_START_ADDRESS, 24'hFFFFFF);
		add_write(srec_s2_pkg::REG_TOTAL_LENGTH, 24'h000001);
		add_byte(8'hFF, 1'b1, "S205FFFFFFFFFE\n", 1'b1);
		// A zero-length image ignores every byte.
		add_write(srec_s2_pkg::REG_TOTAL_LENGTH, 24'h000000);
		add_byte(8'h00, 1'b1, "", 1'b0);
		add_byte(8'h5A, 1'b1, "", 1'b0);
		// Fourteen bytes: a full record wrapping the address, then a short one.
		// Writes to undecoded indexes in the middle must not restart it.
		add_write(srec_s2_pkg::REG_START_ADDRESS, 24'hFFFFFA);
		add_write(srec_s2_pkg::REG_TOTAL_LENGTH, 24'hA5000E);
		add_byte(8'h00, 1'b0, "", 1'b0);
		add_byte(8'hFF, 1'b0, "", 1'b0);
		add_byte(8'h80, 1'b0, "", 1'b0);
		add_byte(8'h7F, 1'b0, "", 1'b0);
		add_byte(8'h01, 1'b0, "", 1'b0);
		add_byte(8'hFE, 1'b0, "", 1'b0);
		add_write(REG_UNUSED_2, 24'hFFFFFF);
		add_write(REG_UNUSED_3, 24'h000000);
		add_byte(8'h3C, 1'b0, "", 1'b0);
		add_byte(8'hC3, 1'b0, "", 1'b0);
		add_byte(8'h55, 1'b0, "", 1'b0);
		add_byte(8'hAA, 1'b0, "", 1'b0);
		add_byte(8'h0F, 1'b0, "", 1'b0);
		add_byte(8'hF0, 1'b0, "", 1'b0);
		add_byte(8'h10, 1'b0, "", 1'b0);
		add_byte(8'hEF, 1'b0, "", 1'b0);
		// Longest image, left unfinished; the next write restarts it.
		add_write(srec_s2_pkg::REG_TOTAL_LENGTH, 24'h00FFFF);
		add_write(srec_s2_pkg::REG_START_ADDRESS, 24'h123456);
		add_byte(8'h11, 1'b0, "", 1'b0);
		add_byte(8'h22, 1'b0, "", 1'b0);
		add_byte(8'h33, 1'b0, "", 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_WRITE) begin
				write_reg(stim_rows[i].index, stim_rows[i].data);
			end else begin
				send_byte(stim_rows[i].data_byte, stim_rows[i].known, stim_rows[i].text,
					stim_rows[i].done);
			end
		end

		// Random images: slow receiver, then slow sender, then full rate.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct    = 6;
					receiver_stall_pct = 73;
				end
				1: begin
					sender_idle_pct    = 73;
					receiver_stall_pct = 6;
				end
				default: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
			endcase
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				random_image();
			end
		end

		// Let the last records drain out.
		byte_if.valid <= 1'b0;
		do @(posedge clk); while (text_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d data words (%0d encoded) and %0d register writes;",
			bytes_sent, bytes_encoded, writes_done);
		$display("checked %0d text words across three flow-control phases, %0d mismatches.",
			words_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/srec_s2_pkg.sv
hw/rtl/srec_s2_if.sv
hw/rtl/srec_s2_front.sv
hw/rtl/srec_s2_queue.sv
hw/rtl/srec_s2_back.sv
hw/rtl/srecord_s2_encoder_top.sv
tb/tb.sv
